// File: rtl/qte_pkg.sv
// ---------------------------------------------------------------------------
// qte_pkg: shared types and constants of the quaternion to euler block
// fixed-point formats, cordic angle table, pre-rotation and output rounding
// ---------------------------------------------------------------------------
package qte_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN     = 24;
	localparam int SQRT_BITS    = 29;
	localparam int VEC_W        = 36;
	localparam int ACC_W        = 26;
	localparam int TERM_W       = 35;
	localparam int T2_W         = 30;
	localparam int RAD_W        = 58;

	localparam logic [13:0] HALF_TURN_OUT    = 14'd11520;
	localparam logic [13:0] QUARTER_TURN_OUT = 14'd5760;
	localparam logic [12:0] WINDOW_RESET     = 13'd2880;
	localparam logic signed [ACC_W-1:0] DEG90_ACC  = 26'sd5898240;
	localparam logic signed [ACC_W-1:0] DEG180_ACC = 26'sd11796480;

	// atan(2^-i) in units of 2^-16 degree
	localparam logic [21:0] ATAN_TABLE [ATAN_LEN] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
		22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
		22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
	};

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ACC_W-1:0] acc;
		logic                    frz;
	} cvec_t;

	typedef struct packed {
		logic [RAD_W-1:0]     rem;
		logic [SQRT_BITS-1:0] root;
	} sqst_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] t0;
		logic signed [TERM_W-1:0] t1;
		logic signed [T2_W-1:0]   t2;
		logic signed [TERM_W-1:0] t3;
		logic signed [TERM_W-1:0] t4;
	} side_t;

	// axis cases and quadrant fold ahead of the micro-rotations
	function automatic cvec_t cordic_init(logic signed [VEC_W-1:0] y,
			logic signed [VEC_W-1:0] x);
		cvec_t v;
		v.x   = x;
		v.y   = y;
		v.acc = '0;
		v.frz = 1'b0;
		if (y == '0) begin
			v.frz = 1'b1;
			v.acc = x[VEC_W-1] ? DEG180_ACC : '0;
		end else if (x == '0) begin
			v.frz = 1'b1;
			v.acc = y[VEC_W-1] ? -DEG90_ACC : DEG90_ACC;
		end else if (x[VEC_W-1]) begin
			if (!y[VEC_W-1]) begin
				v.x   = y;
				v.y   = -x;
				v.acc = DEG90_ACC;
			end else begin
				v.x   = -y;
				v.y   = x;
				v.acc = -DEG90_ACC;
			end
		end
		return v;
	endfunction

	// 2^-16 degree to 1/64 degree, half away from zero, then saturate
	function automatic logic signed [14:0] to_out(logic signed [ACC_W-1:0] acc,
			logic [13:0] lim);
		logic [ACC_W-1:0] mag;
		logic [16:0]      r;
		logic [14:0]      s;
		mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
		r   = 17'((mag + ACC_W'(512)) >> 10);
		s   = (r > 17'(lim)) ? 15'(lim) : 15'(r);
		return acc[ACC_W-1] ? -$signed(s) : $signed(s);
	endfunction

endpackage

// File: rtl/qte_sqrt_cell.sv
// ---------------------------------------------------------------------------
// qte_sqrt_cell: one root bit of the integer square root chain
// tries the given root bit and keeps it when the remainder allows
// ---------------------------------------------------------------------------
module qte_sqrt_cell #(
	parameter int BIT = 0
) (
	input  logic           clk,
	input  logic           en,
	input  qte_pkg::sqst_t din,
	output qte_pkg::sqst_t dout
);

	logic [qte_pkg::RAD_W-1:0] trial;
	qte_pkg::sqst_t            nxt;

	// trial = (root << (bit+1)) + 4^bit
	always_comb begin
		trial = (qte_pkg::RAD_W'(din.root) << (BIT + 1))
			+ (qte_pkg::RAD_W'(1) << (2 * BIT));
		nxt = din;
		if (din.rem >= trial) begin
			nxt.rem  = din.rem - trial;
			nxt.root = din.root | (qte_pkg::SQRT_BITS'(1) << BIT);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

// File: rtl/qte_cordic_cell.sv
// ---------------------------------------------------------------------------
// qte_cordic_cell: one vectoring micro-rotation of the cordic chain
// rotates toward the x axis and books the step angle
// ---------------------------------------------------------------------------
module qte_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           en,
	input  qte_pkg::cvec_t din,
	output qte_pkg::cvec_t dout
);

	qte_pkg::cvec_t nxt;

	generate
		if (STEP < qte_pkg::ATAN_LEN) begin : g_rot
			logic signed [qte_pkg::VEC_W-1:0] xs;
			logic signed [qte_pkg::VEC_W-1:0] ys;
			logic signed [qte_pkg::ACC_W-1:0] da;

			assign xs = din.x >>> STEP;
			assign ys = din.y >>> STEP;
			assign da = $signed({4'd0, qte_pkg::ATAN_TABLE[STEP]});

			// sign of y picks the rotation direction; frozen lanes keep the angle
			always_comb begin
				nxt = din;
				if (!din.y[qte_pkg::VEC_W-1]) begin
					nxt.x = din.x + ys;
					nxt.y = din.y - xs;
					if (!din.frz) nxt.acc = din.acc + da;
				end else begin
					nxt.x = din.x - ys;
					nxt.y = din.y + xs;
					if (!din.frz) nxt.acc = din.acc - da;
				end
			end
		end else begin : g_skip
			assign nxt = din;
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

// File: rtl/quaternion_to_euler_angles.sv
// ---------------------------------------------------------------------------
// quaternion_to_euler_angles: Z-Y-X euler angles from a Q1.14 quaternion
// products, square root chain and three cordic chains in one pipeline
// ---------------------------------------------------------------------------
// Takes one quaternion per cycle and returns roll, pitch and yaw in 1/64
// degree plus a pitch window flag. The pipeline holds 4 arithmetic stages,
// 29 square root cells, one quadrant fold stage, one cell per cordic step
// and the output register. The whole pipeline
// advances whenever the output register is empty or its transfer completes,
// so a new item is taken every cycle while the result side keeps up.
module quaternion_to_euler_angles #(
	parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS
) (
	input  logic        clk,
	input  logic        arst_n,
	// w [15:0], x [31:16], y [47:32], z [63:48]
	input  logic [63:0] s_axis_tdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// roll [14:0], pitch [28:15], yaw [43:29], pitch_in_window [44], zero [47:45]
	output logic [47:0] m_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata
);

	localparam int NS = 4 + qte_pkg::SQRT_BITS + 1 + CORDIC_STEPS + 1;

	logic          en;
	logic [NS-1:0] vld_q;
	logic [12:0]   pitch_window_q;

	logic signed [15:0] qw, qx, qy, qz;
	logic signed [31:0] p_wx_s1, p_yz_s1, p_xx_s1, p_yy_s1, p_wy_s1;
	logic signed [31:0] p_zx_s1, p_wz_s1, p_xy_s1, p_zz_s1;
	logic signed [qte_pkg::TERM_W-1:0] t2_raw;
	qte_pkg::side_t side_s2, side_s3, side_s4;
	logic signed [2*qte_pkg::T2_W-1:0] sq_prod;
	logic [qte_pkg::RAD_W-1:0] sq_s3, v_s4;

	qte_pkg::sqst_t sq_chain   [qte_pkg::SQRT_BITS+1];
	qte_pkg::side_t side_chain [1:qte_pkg::SQRT_BITS];
	qte_pkg::cvec_t roll_fold_q, pitch_fold_q, yaw_fold_q;
	qte_pkg::cvec_t roll_chain  [CORDIC_STEPS+1];
	qte_pkg::cvec_t pitch_chain [CORDIC_STEPS+1];
	qte_pkg::cvec_t yaw_chain   [CORDIC_STEPS+1];

	logic signed [14:0] roll_r, yaw_r, pitch_w;
	logic signed [13:0] pitch_r;
	logic [13:0]        pitch_mag;
	logic signed [14:0] roll_q, yaw_q;
	logic signed [13:0] pitch_q;
	logic               win_q;

	// global advance: output register free or being taken
	assign en            = !vld_q[NS-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[NS-1];

	// valid bits follow the data down the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NS-2:0], s_axis_tvalid};
		end
	end

	// window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_window_q <= qte_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			pitch_window_q <= cfg_wdata;
		end
	end

	assign qw = $signed(s_axis_tdata[15:0]);
	assign qx = $signed(s_axis_tdata[31:16]);
	assign qy = $signed(s_axis_tdata[47:32]);
	assign qz = $signed(s_axis_tdata[63:48]);

	// stage 1: component products
	always_ff @(posedge clk) begin
		if (en) begin
			p_wx_s1 <= qw * qx;
			p_yz_s1 <= qy * qz;
			p_xx_s1 <= qx * qx;
			p_yy_s1 <= qy * qy;
			p_wy_s1 <= qw * qy;
			p_zx_s1 <= qz * qx;
			p_wz_s1 <= qw * qz;
			p_xy_s1 <= qx * qy;
			p_zz_s1 <= qz * qz;
		end
	end

	// stage 2: rotation matrix terms, t2 clamped to plus or minus one
	assign t2_raw = (qte_pkg::TERM_W'(p_wy_s1) - qte_pkg::TERM_W'(p_zx_s1)) <<< 1;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.t0 <= (qte_pkg::TERM_W'(p_wx_s1) + qte_pkg::TERM_W'(p_yz_s1)) <<< 1;
			side_s2.t1 <= (qte_pkg::TERM_W'(1) <<< 28)
				- ((qte_pkg::TERM_W'(p_xx_s1) + qte_pkg::TERM_W'(p_yy_s1)) <<< 1);
			side_s2.t3 <= (qte_pkg::TERM_W'(p_wz_s1) + qte_pkg::TERM_W'(p_xy_s1)) <<< 1;
			side_s2.t4 <= (qte_pkg::TERM_W'(1) <<< 28)
				- ((qte_pkg::TERM_W'(p_yy_s1) + qte_pkg::TERM_W'(p_zz_s1)) <<< 1);
			if (t2_raw > (qte_pkg::TERM_W'(1) <<< 28)) begin
				side_s2.t2 <= qte_pkg::T2_W'(1) <<< 28;
			end else if (t2_raw < -(qte_pkg::TERM_W'(1) <<< 28)) begin
				side_s2.t2 <= -(qte_pkg::T2_W'(1) <<< 28);
			end else begin
				side_s2.t2 <= qte_pkg::T2_W'(t2_raw);
			end
		end
	end

	// stage 3: t2 squared
	assign sq_prod = side_s2.t2 * side_s2.t2;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3   <= sq_prod[qte_pkg::RAD_W-1:0];
			side_s3 <= side_s2;
		end
	end

	// stage 4: radicand one minus t2 squared
	always_ff @(posedge clk) begin
		if (en) begin
			v_s4    <= (qte_pkg::RAD_W'(1) << 56) - sq_s3;
			side_s4 <= side_s3;
		end
	end

	assign sq_chain[0] = '{rem: v_s4, root: '0};

	// square root chain, most significant root bit first
	for (genvar j = 0; j < qte_pkg::SQRT_BITS; j++) begin : g_sqrt
		qte_sqrt_cell #(
			.BIT(qte_pkg::SQRT_BITS - 1 - j)
		) u_cell (
			.clk (clk),
			.en  (en),
			.din (sq_chain[j]),
			.dout(sq_chain[j+1])
		);

		if (j == 0) begin : g_side_first
			always_ff @(posedge clk) begin
				if (en) begin
					side_chain[1] <= side_s4;
				end
			end
		end else begin : g_side_next
			always_ff @(posedge clk) begin
				if (en) begin
					side_chain[j+1] <= side_chain[j];
				end
			end
		end
	end

	// quadrant fold and axis cases for the three lanes
	always_ff @(posedge clk) begin
		if (en) begin
			roll_fold_q <= qte_pkg::cordic_init(
				qte_pkg::VEC_W'(side_chain[qte_pkg::SQRT_BITS].t0),
				qte_pkg::VEC_W'(side_chain[qte_pkg::SQRT_BITS].t1));
			pitch_fold_q <= qte_pkg::cordic_init(
				qte_pkg::VEC_W'(side_chain[qte_pkg::SQRT_BITS].t2),
				$signed({{(qte_pkg::VEC_W - qte_pkg::SQRT_BITS){1'b0}},
					sq_chain[qte_pkg::SQRT_BITS].root}));
			yaw_fold_q <= qte_pkg::cordic_init(
				qte_pkg::VEC_W'(side_chain[qte_pkg::SQRT_BITS].t3),
				qte_pkg::VEC_W'(side_chain[qte_pkg::SQRT_BITS].t4));
		end
	end

	assign roll_chain[0]  = roll_fold_q;
	assign pitch_chain[0] = pitch_fold_q;
	assign yaw_chain[0]   = yaw_fold_q;

	// cordic chains, one cell per micro-rotation
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		qte_cordic_cell #(.STEP(i)) u_roll (
			.clk (clk),
			.en  (en),
			.din (roll_chain[i]),
			.dout(roll_chain[i+1])
		);
		qte_cordic_cell #(.STEP(i)) u_pitch (
			.clk (clk),
			.en  (en),
			.din (pitch_chain[i]),
			.dout(pitch_chain[i+1])
		);
		qte_cordic_cell #(.STEP(i)) u_yaw (
			.clk (clk),
			.en  (en),
			.din (yaw_chain[i]),
			.dout(yaw_chain[i+1])
		);
	end

	// rounding to output units and window test
	assign roll_r    = qte_pkg::to_out(roll_chain[CORDIC_STEPS].acc, qte_pkg::HALF_TURN_OUT);
	assign yaw_r     = qte_pkg::to_out(yaw_chain[CORDIC_STEPS].acc, qte_pkg::HALF_TURN_OUT);
	assign pitch_w   = qte_pkg::to_out(pitch_chain[CORDIC_STEPS].acc,
		qte_pkg::QUARTER_TURN_OUT);
	assign pitch_r   = pitch_w[13:0];
	assign pitch_mag = pitch_r[13] ? 14'(-pitch_r) : 14'(pitch_r);

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			roll_q  <= roll_r;
			pitch_q <= pitch_r;
			yaw_q   <= yaw_r;
			win_q   <= (pitch_mag <= {1'b0, pitch_window_q});
		end
	end

	assign m_axis_tdata = {3'd0, win_q, yaw_q, pitch_q, roll_q};

endmodule

// File: dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench of quaternion_to_euler_angles
// drives quaternions through the stream input with random gaps, predicts roll,
// pitch, yaw and the window flag with its own fixed-point cordic, and checks
// every output transfer against the oldest prediction
// ---------------------------------------------------------------------------
module tb_top;

	localparam int PIPE_LAT = 35 + qte_pkg::CORDIC_STEPS;

	// w in the lowest bits, matching the input tdata layout
	typedef struct packed {
		logic signed [15:0] z;
		logic signed [15:0] y;
		logic signed [15:0] x;
		logic signed [15:0] w;
	} quat_t;

	typedef struct packed {
		logic               in_win;
		logic signed [14:0] yaw;
		logic signed [13:0] pitch;
		logic signed [14:0] roll;
	} euler_t;

	logic        clk;
	logic        arst_n;
	logic [63:0] s_axis_tdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic        cfg_we;
	logic [12:0] cfg_wdata;

	quat_t   quat_queue[$];
	euler_t  euler_queue[$];
	logic [12:0] window_model;
	int      errors;
	int      send_gap;
	int      recv_gap;
	bit      hold_off;
	bit      stim_done;
	logic    s_axis_tready_q;
	logic    m_axis_valid_q;

	quaternion_to_euler_angles i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// floor square root of a 64-bit value
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bit_val;
		res = 0;
		bit_val = 64'd1 << 62;
		while (bit_val > v) bit_val >>= 2;
		while (bit_val != 0) begin
			if (v >= res + bit_val) begin
				v -= res + bit_val;
				res = (res >> 1) + bit_val;
			end else begin
				res >>= 1;
			end
			bit_val >>= 2;
		end
		return res;
	endfunction

	// atan2 in 2^-16 degree by vectoring cordic
	function automatic longint vector_angle(longint y, longint x);
		longint acc;
		longint t;
		longint xs;
		longint ys;
		acc = 0;
		if (y == 0) return (x < 0) ? 64'(qte_pkg::DEG180_ACC) : 0;
		if (x == 0) return (y > 0) ? 64'(qte_pkg::DEG90_ACC) : -64'(qte_pkg::DEG90_ACC);
		if (x < 0) begin
			if (y > 0) begin
				t = x; x = y; y = -t; acc = qte_pkg::DEG90_ACC;
			end else begin
				t = x; x = -y; y = t; acc = -64'(qte_pkg::DEG90_ACC);
			end
		end
		for (int i = 0; i < qte_pkg::CORDIC_STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; acc += longint'(qte_pkg::ATAN_TABLE[i]);
			end else begin
				x = x - ys; y = y + xs; acc -= longint'(qte_pkg::ATAN_TABLE[i]);
			end
		end
		return acc;
	endfunction

	// 2^-16 degree to 1/64 degree, half away from zero, saturated
	function automatic longint angle_units(longint acc, longint lim);
		longint r;
		r = (acc >= 0) ? ((acc + 512) >>> 10) : -((-acc + 512) >>> 10);
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic euler_t euler_of(quat_t q, logic [12:0] win);
		longint w, x, y, z, t0, t1, t2, t3, t4, c, p;
		longint one;
		euler_t e;
		one = 64'd1 << 28;
		w = q.w; x = q.x; y = q.y; z = q.z;
		t0 = 2 * (w * x + y * z);
		t1 = one - 2 * (x * x + y * y);
		t2 = 2 * (w * y - z * x);
		t3 = 2 * (w * z + x * y);
		t4 = one - 2 * (y * y + z * z);
		if (t2 > one) t2 = one;
		if (t2 < -one) t2 = -one;
		c = longint'(int_sqrt(longint'(one * one - t2 * t2)));
		e.roll  = 15'(angle_units(vector_angle(t0, t1), 11520));
		p       = angle_units(vector_angle(t2, c), 5760);
		e.pitch = 14'(p);
		e.yaw   = 15'(angle_units(vector_angle(t3, t4), 11520));
		e.in_win = ((p < 0 ? -p : p) <= longint'(win));
		return e;
	endfunction

	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// random unit-ish quaternion with a slightly perturbed norm
	function automatic quat_t rand_unit();
		real a, b, c, d, n;
		quat_t q;
		a = $signed($urandom_range(0, 20000)) - 10000;
		b = $signed($urandom_range(0, 20000)) - 10000;
		c = $signed($urandom_range(0, 20000)) - 10000;
		d = $signed($urandom_range(0, 20000)) - 10000;
		n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
		q.w = 16'($rtoi(a / n * 16384.0) + $signed($urandom_range(0, 6)) - 3);
		q.x = 16'($rtoi(b / n * 16384.0));
		q.y = 16'($rtoi(c / n * 16384.0));
		q.z = 16'($rtoi(d / n * 16384.0));
		return q;
	endfunction

	task automatic push_quat(logic signed [15:0] w, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z);
		quat_t q;
		q = '{w: w, x: x, y: y, z: z};
		quat_queue.push_back(q);
	endtask

	// wait at rising edges until nothing is queued, offered or in flight
	task automatic wait_drained();
		do begin
			@(posedge clk);
		end while (quat_queue.size() != 0 || s_axis_tvalid || euler_queue.size() != 0);
	endtask

	// register write while the pipeline is drained
	task automatic write_window(logic [12:0] val);
		wait_drained();
		repeat (PIPE_LAT + 4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		window_model = val;
	endtask

	// input driver and result-side ready
	always @(negedge clk) begin
		int gap;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready_q) begin
				gap = $urandom_range(0, 4);
				if (gap == 0 && !hold_off && quat_queue.size() != 0) begin
					s_axis_tdata <= quat_queue.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
					send_gap <= (gap > 0) ? gap - 1 : 0;
				end
			end else if (!s_axis_tvalid && !hold_off && quat_queue.size() != 0) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
				end else begin
					s_axis_tdata  <= quat_queue.pop_front();
					s_axis_tvalid <= 1'b1;
				end
			end
			if (!m_axis_tready) begin
				if (recv_gap > 0) recv_gap <= recv_gap - 1;
				else m_axis_tready <= 1'b1;
			end else if (m_axis_valid_q) begin
				m_axis_tready <= ($urandom_range(0, 3) != 0);
				recv_gap <= $urandom_range(0, 4);
			end
		end
	end

	// rising-edge samples of the handshakes for the driver
	always @(posedge clk) begin
		s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
		m_axis_valid_q  <= m_axis_tvalid && m_axis_tready;
	end

	// prediction at each input transfer, check at each output transfer
	always @(posedge clk) begin
		euler_t got;
		euler_t want;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			euler_queue.push_back(euler_of(quat_t'(s_axis_tdata), window_model));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = euler_t'(m_axis_tdata[44:0]);
			if (euler_queue.size() == 0) begin
				$error("unexpected result transfer %h", m_axis_tdata);
				errors++;
			end else begin
				want = euler_queue.pop_front();
				if (got.roll !== want.roll) begin
					$error("roll_angle expected %0d got %0d", want.roll, got.roll);
					errors++;
				end
				if (got.pitch !== want.pitch) begin
					$error("pitch_angle expected %0d got %0d", want.pitch, got.pitch);
					errors++;
				end
				if (got.yaw !== want.yaw) begin
					$error("yaw_angle expected %0d got %0d", want.yaw, got.yaw);
					errors++;
				end
				if (got.in_win !== want.in_win) begin
					$error("pitch_in_window expected %0b got %0b", want.in_win, got.in_win);
					errors++;
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [12:0] settings[4];
		settings = '{13'd0, 13'd5760, 13'd8191, 13'd1234};
		arst_n = 1'b0;
		s_axis_tdata = '0;
		s_axis_tvalid = 1'b0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		errors = 0;
		send_gap = 0;
		recv_gap = 0;
		hold_off = 1'b0;
		stim_done = 1'b0;
		window_model = qte_pkg::WINDOW_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: identity, axes, gimbal lock, zero vector, extremes
		push_quat(16384, 0, 0, 0);
		push_quat(-16384, 0, 0, 0);
		push_quat(0, 16384, 0, 0);
		push_quat(0, 0, 16384, 0);
		push_quat(0, 0, 0, 16384);
		push_quat(11585, 0, 11585, 0);
		push_quat(11585, 0, -11585, 0);
		push_quat(16384, 0, 16384, 0);
		push_quat(16384, 0, -16384, 0);
		push_quat(0, 0, 0, 0);
		push_quat(11585, 11585, 0, 0);
		push_quat(11585, 0, 0, -11585);
		push_quat(-32768, -32768, -32768, -32768);
		push_quat(32767, 32767, 32767, 32767);
		push_quat(-32768, 32767, -1, 1);
		push_quat(8192, 8192, 8192, 8192);
		push_quat(8192, -8192, 8192, -8192);
		push_quat(1, -1, 1, -1);
		push_quat(0, 11585, 11585, 0);
		push_quat(16384, 16384, 16384, 16384);

		// pause until every result is back, then sweep the window register
		for (int s = 0; s < 4; s++) begin
			write_window(settings[s]);
			for (int i = 0; i < 160; i++) begin
				if ($urandom_range(0, 3) == 0)
					push_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
				else
					quat_queue.push_back(rand_unit());
			end
			if (s == 1) begin
				// let the sender sit idle for a while mid-phase
				wait (quat_queue.size() < 80);
				hold_off = 1'b1;
				do begin
					@(posedge clk);
				end while (euler_queue.size() != 0 || s_axis_tvalid);
				hold_off = 1'b0;
			end
		end
		write_window(qte_pkg::WINDOW_RESET);
		push_quat(16384, 0, 0, 0);
		wait_drained();
		repeat (PIPE_LAT + 10) @(posedge clk);
		if (errors == 0 && euler_queue.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// run limit
	initial begin
		#4000000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

// File: sim.f
rtl/qte_pkg.sv
rtl/qte_sqrt_cell.sv
rtl/qte_cordic_cell.sv
rtl/quaternion_to_euler_angles.sv
dv/tb_top.sv
